### src/mmp_pkg.sv
// Shared types, constants and helper functions of the mipmap pyramid generator.
package mmp_pkg;

    // Widths of the channel payloads.
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = 10;
    localparam int NCH     = 4;
    localparam int LEVEL_W = 4;
    localparam int COORD_W = 9;
    localparam int CFG_W   = 4;
    localparam int CIDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
    localparam logic [CIDX_W-1:0] REG_CHAN_COUNT  = 2'd2;

    // Four channel partial sums; channel 3 holds a running maximum.
    typedef logic [NCH-1:0][SUM_W-1:0] px4_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_COMB
    } mmp_state_t;

    // Control from the sequencer to one level cell.
    typedef struct packed {
        logic clear;
        logic step;
    } cell_ctrl_t;

    // Status of one level cell seen by the sequencer.
    typedef struct packed {
        logic emit_pred;
        logic w_one;
        logic h_one;
        logic col_odd;
        logic row_odd;
        px4_t hold;
    } cell_status_t;

    // Sums channels 0..2 and takes the maximum of channel 3.
    function automatic px4_t combine(px4_t a, px4_t b);
        px4_t r;
        for (int c = 0; c < 3; c++)
        begin
            r[c] = a[c] + b[c];
        end
        r[3] = (a[3] > b[3]) ? a[3] : b[3];
        return r;
    endfunction

endpackage

### src/mmp_if.sv
// Valid/ready channel interfaces for base pixels and produced texels.
interface mmp_in_if;
    import mmp_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan3;

    modport source (output valid, chan0, chan1, chan2, chan3, input ready);
    modport sink (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface mmp_out_if;
    import mmp_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] texel_x;
    logic [COORD_W-1:0] texel_y;
    logic [CHAN_W-1:0]  out0;
    logic [CHAN_W-1:0]  out1;
    logic [CHAN_W-1:0]  out2;
    logic [CHAN_W-1:0]  out3;
    logic               last_of_run;

    modport source (output valid, level, texel_x, texel_y, out0, out1, out2, out3,
                    last_of_run, input ready);
    modport sink (input valid, level, texel_x, texel_y, out0, out1, out2, out3,
                  last_of_run, output ready);
endinterface

### src/mmp_ram.sv
// Generic single-port-write, registered-read RAM.
module mmp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### src/mmp_cell.sv
// One pyramid level cell: position counters and the even-column texel hold.
module mmp_cell #(
    parameter int MAX_SIZE_LOG2 = 10,
    parameter int LVL = 0,
    localparam int CW = MAX_SIZE_LOG2,
    localparam int LW = $clog2(MAX_SIZE_LOG2 + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mmp_pkg::cell_ctrl_t  ctrl,
    input  logic [LW-1:0]        wl,
    input  logic [LW-1:0]        hl,
    input  mmp_pkg::px4_t        t,
    output mmp_pkg::cell_status_t status,
    output logic [CW-1:0]        cx,
    output logic [CW-1:0]        cy,
    output logic [CW-1:0]        half
);
    import mmp_pkg::*;

    logic [CW-1:0] cx_reg, cx_next;
    logic [CW-1:0] cy_reg, cy_next;
    px4_t          hold_reg;
    logic [CW:0]   wfull, hfull;
    logic [CW-1:0] wmask, hmask;
    logic          w_one, h_one;

    // Last column and row index of this level.
    assign w_one = !(LW'(LVL) < wl);
    assign h_one = !(LW'(LVL) < hl);
    assign wfull = ~({(CW+1){1'b1}} << (wl - LW'(LVL)));
    assign hfull = ~({(CW+1){1'b1}} << (hl - LW'(LVL)));
    assign wmask = w_one ? '0 : wfull[CW-1:0];
    assign hmask = h_one ? '0 : hfull[CW-1:0];
    assign half  = CW'((wmask >> 1) + 1'b1);

    // Raster position step with wrap at the end of the level.
    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (ctrl.clear)
        begin
            cx_next = '0;
            cy_next = '0;
        end
        else if (ctrl.step)
        begin
            if (cx_reg == wmask)
            begin
                cx_next = '0;
                cy_next = (cy_reg == hmask) ? '0 : CW'(cy_reg + 1'b1);
            end
            else
            begin
                cx_next = CW'(cx_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    // Even-column texel waits here for its right-hand partner.
    always_ff @(posedge clk)
    begin
        if (ctrl.step && !w_one && !cx_reg[0])
        begin
            hold_reg <= t;
        end
    end

    assign cx               = cx_reg;
    assign cy               = cy_reg;
    assign status.w_one     = w_one;
    assign status.h_one     = h_one;
    assign status.col_odd   = cx_reg[0];
    assign status.row_odd   = cy_reg[0];
    assign status.hold      = hold_reg;
    assign status.emit_pred = (w_one || cx_reg[0]) && (h_one || cy_reg[0]);
endmodule

### src/mipmap_pyramid_generator_unit.sv
// Top level of the streaming box-filter mipmap pyramid generator.
//
// Base-level pixels enter on pix_in in raster order, one transaction per pixel.
// Every texel of levels 1 and up leaves on texel_out as soon as its 2x2 source
// block is complete; one pixel causes at most one texel per level, in rising
// level order, and last_of_run marks the final texel of that pixel.
// Configuration (width_log2, height_log2, channel_count) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce; a write restarts the texture.
// A pixel walks the chain of level cells one level at a time; a level that
// produces a texel adds a combine step for the row store read and the output
// load. A pixel that only fills a hold returns to idle after its level step.
// Pixels are taken one at a time, a new one only after the last is through.
// The even-row pair sums of all levels share one row store RAM of
// 2^MAX_SIZE_LOG2 entries, written or read at most once per level step.
// Reset clears the counters and configuration to a 256x256 RGBA texture; the
// stores need no clearing. A stalled receiver holds the texel in the output
// register and the sequencer waits before loading the next one.
module mipmap_pyramid_generator_unit #(
    parameter int MAX_SIZE_LOG2 = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mmp_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [mmp_pkg::CFG_W-1:0]     cfg_data,
    mmp_in_if.sink                        pix_in,
    mmp_out_if.source                     texel_out
);
    import mmp_pkg::*;

    localparam int CW    = MAX_SIZE_LOG2;
    localparam int LW    = $clog2(MAX_SIZE_LOG2 + 1);
    localparam int NCELL = MAX_SIZE_LOG2;
    localparam int IW    = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int DEPTH = 1 << MAX_SIZE_LOG2;

    mmp_state_t state_reg, state_next;

    logic [3:0]          wl_reg;
    logic [3:0]          hl_reg;
    logic [2:0]          cc_reg;
    logic [LW-1:0]       wl_c, hl_c, nlev;
    logic [2:0]          cc_c;
    logic                cfg_hit;

    logic [LW-1:0]       s_reg;
    logic [LW-1:0]       s_plus;
    logic [CW-1:0]       off_reg;
    logic [NCH-1:0][CHAN_W-1:0] t_reg;
    logic [NCH-1:0][CHAN_W-1:0] t_in;
    logic [NCH-1:0][CHAN_W-1:0] t_next;
    px4_t                t_ext;
    px4_t                pair_now, pair_reg, full;
    logic                self_reg;
    logic [CW-1:0]       cx_reg, cy_reg, half_reg;

    cell_ctrl_t          ctrl   [NCELL];
    cell_status_t        cst    [NCELL];
    logic [CW-1:0]       ccx    [NCELL];
    logic [CW-1:0]       ccy    [NCELL];
    logic [CW-1:0]       chalf  [NCELL];
    cell_status_t        cur;
    logic [CW-1:0]       cur_cx, cur_cy, cur_half;

    logic                in_range, pair_rdy, emit, more;
    logic                mem_we, mem_re;
    logic [CW-1:0]       mem_addr;
    logic [SUM_W*NCH-1:0] mem_rdata;
    px4_t                row_src;

    logic                accept, load;
    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [COORD_W-1:0]  tx_reg, ty_reg;
    logic [NCH-1:0][CHAN_W-1:0] oval_reg;
    logic                last_reg;

    // Configuration registers and effective limits.
    assign cfg_hit = cfg_we && (cfg_index == REG_WIDTH_LOG2 || cfg_index == REG_HEIGHT_LOG2
                                || cfg_index == REG_CHAN_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= 4'd8;
            hl_reg <= 4'd8;
            cc_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH_LOG2:  wl_reg <= cfg_data;
                REG_HEIGHT_LOG2: hl_reg <= cfg_data;
                REG_CHAN_COUNT:  cc_reg <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    assign wl_c = (int'(wl_reg) > MAX_SIZE_LOG2) ? LW'(MAX_SIZE_LOG2) : LW'(wl_reg);
    assign hl_c = (int'(hl_reg) > MAX_SIZE_LOG2) ? LW'(MAX_SIZE_LOG2) : LW'(hl_reg);
    assign nlev = (wl_c > hl_c) ? wl_c : hl_c;
    assign cc_c = (cc_reg == 3'd0) ? 3'd1 : ((cc_reg > 3'd4) ? 3'd4 : cc_reg);

    // Unused channels read as zero.
    assign t_in[0] = pix_in.chan0;
    assign t_in[1] = (cc_c > 3'd1) ? pix_in.chan1 : '0;
    assign t_in[2] = (cc_c > 3'd2) ? pix_in.chan2 : '0;
    assign t_in[3] = (cc_c > 3'd3) ? pix_in.chan3 : '0;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            t_ext[c] = SUM_W'(t_reg[c]);
        end
    end

    // Chain of level cells.
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        assign ctrl[i].clear = cfg_hit;
        assign ctrl[i].step  = (state_reg == ST_LEVEL) && in_range && (s_reg == LW'(i));
        mmp_cell #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2), .LVL(i)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl[i]),
            .wl     (wl_c),
            .hl     (hl_c),
            .t      (t_ext),
            .status (cst[i]),
            .cx     (ccx[i]),
            .cy     (ccy[i]),
            .half   (chalf[i])
        );
    end

    // Current level cell and the one after it.
    assign cur      = cst[s_reg[IW-1:0]];
    assign cur_cx   = ccx[s_reg[IW-1:0]];
    assign cur_cy   = ccy[s_reg[IW-1:0]];
    assign cur_half = chalf[s_reg[IW-1:0]];
    assign s_plus   = LW'(s_reg + 1'b1);
    assign more     = (s_plus < nlev) && cst[s_plus[IW-1:0]].emit_pred;

    // Horizontal pair and row store access of the current level.
    assign in_range = s_reg < nlev;
    assign pair_now = cur.w_one ? combine(t_ext, t_ext) : combine(cur.hold, t_ext);
    assign pair_rdy = cur.w_one || cur.col_odd;
    assign emit     = in_range && pair_rdy && (cur.h_one || cur.row_odd);
    assign mem_we   = (state_reg == ST_LEVEL) && in_range && pair_rdy && !cur.h_one
                      && !cur.row_odd;
    assign mem_re   = (state_reg == ST_LEVEL) && in_range && pair_rdy && !cur.h_one
                      && cur.row_odd;
    assign mem_addr = CW'(off_reg + (cur_cx >> 1));

    mmp_ram #(.WIDTH(SUM_W*NCH), .DEPTH(DEPTH)) u_row_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (pair_now),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    // Vertical combine and the texel passed on to the next level.
    assign row_src = self_reg ? pair_reg : px4_t'(mem_rdata);
    assign full    = combine(row_src, pair_reg);
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            t_next[c] = full[c][SUM_W-1:2];
        end
        t_next[3] = full[3][CHAN_W-1:0];
    end

    assign accept = pix_in.valid && pix_in.ready;
    assign load   = (state_reg == ST_COMB) && (!out_valid_reg || texel_out.ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && nlev != '0)
                begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                state_next = emit ? ST_COMB : ST_IDLE;
            end
            ST_COMB:
            begin
                if (load)
                begin
                    state_next = ST_LEVEL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        pix_in.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:  pix_in.ready = 1'b1;
            ST_LEVEL: pix_in.ready = 1'b0;
            ST_COMB:  pix_in.ready = 1'b0;
            default:  pix_in.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Walk state of the pixel in flight.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg   <= '0;
            off_reg <= '0;
            t_reg   <= t_in;
        end
        else if (load)
        begin
            s_reg   <= s_plus;
            off_reg <= CW'(off_reg + half_reg);
            t_reg   <= t_next;
        end
        if (state_reg == ST_LEVEL)
        begin
            pair_reg <= pair_now;
            self_reg <= cur.h_one;
            cx_reg   <= cur_cx;
            cy_reg   <= cur_cy;
            half_reg <= cur_half;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (texel_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg <= LEVEL_W'(s_plus);
            tx_reg    <= COORD_W'(cx_reg >> 1);
            ty_reg    <= COORD_W'(cy_reg >> 1);
            oval_reg  <= t_next;
            last_reg  <= !more;
        end
    end

    assign texel_out.valid       = out_valid_reg;
    assign texel_out.level       = level_reg;
    assign texel_out.texel_x     = tx_reg;
    assign texel_out.texel_y     = ty_reg;
    assign texel_out.out0        = oval_reg[0];
    assign texel_out.out1        = oval_reg[1];
    assign texel_out.out2        = oval_reg[2];
    assign texel_out.out3        = oval_reg[3];
    assign texel_out.last_of_run = last_reg;

    // The row store is never written and read in the same cycle.
    a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("row store read and write collide");

    // A combine step always belongs to a level inside the pyramid.
    a_comb_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMB) |-> (s_reg < nlev))
        else $error("combine outside the active levels");

    // An accepted pixel never jumps straight to the combine step.
    a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_COMB))
        else $error("pixel skipped its level step");

    // A loaded texel is never lost while the receiver stalls.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !texel_out.ready) |-> !load)
        else $error("output register overwritten");
endmodule
